### rtl/core/wnsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnsb_pkg
// Shared constants and word types for the wrapping next-set-bit finder.
// ----------------------------------------------------------------------------
package wnsb_pkg;

   localparam int SIZE    = 1024;
   localparam int IDX_W   = $clog2(SIZE);
   localparam int NODE_W  = IDX_W + 1;
   localparam int FOUND_W = 11;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FIND  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] bit_index;
      logic       set_value;
   } req_type;

   typedef struct packed {
      logic               bit_read;
      logic [FOUND_W-1:0] found_index;
      logic               none_found;
   } rsp_type;

   typedef struct packed {
      logic ready;
      logic done;
   } wnsb_status_type;

endpackage

### rtl/core/wnsb_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnsb_tree
// Bitmap plus OR summary tree in one pair-wide memory, walked by a sequencer.
// Entry k holds nodes {2k+1, 2k}; entry 0 bit 1 is the root.
// ----------------------------------------------------------------------------
module wnsb_tree (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  wnsb_pkg::req_type         cmd,
   input  logic                      out_hold,
   output wnsb_pkg::wnsb_status_type status,
   output wnsb_pkg::rsp_type         result
);
   import wnsb_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR,
      ST_RD,
      ST_ROOT,
      ST_CLIMB,
      ST_DESC,
      ST_DONE
   } state_type;

   logic [1:0]        mem [SIZE];
   logic [1:0]        rd_data_ff;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic              cur_ff, cur_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   rsp_type           res_ff, res_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [1:0]        mem_wd;
   logic [IDX_W-1:0]  mem_ra;
   logic              done;

   logic [NODE_W-1:0] leaf;
   logic [NODE_W-1:0] node_inc;
   logic [NODE_W-1:0] climb_next;
   logic [NODE_W-1:0] desc_next;
   logic [1:0]        pair_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign leaf      = {1'b1, cmd.bit_index[IDX_W-1:0]};
   assign node_inc  = node_ff + NODE_W'(1);
   assign desc_next = {node_ff[IDX_W-1:0], ~rd_data_ff[0]};

   always_comb begin
      if ((node_ff & node_inc) == '0) begin
         climb_next = NODE_W'(1);
      end else if (node_ff[0]) begin
         climb_next = node_inc;
      end else begin
         climb_next = node_ff >> 1;
      end
   end

   always_comb begin
      pair_new             = rd_data_ff;
      pair_new[node_ff[0]] = cur_ff;
   end

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      cur_in   = cur_ff;
      clr_in   = clr_ff;
      res_in   = res_ff;
      mem_we   = 1'b0;
      mem_wa   = node_ff[NODE_W-1:1];
      mem_wd   = '0;
      mem_ra   = node_ff[NODE_W-1:1];
      done     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + IDX_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_ra = leaf[NODE_W-1:1];
            if (start) begin
               node_in = leaf;
               cur_in  = cmd.set_value;
               res_in  = '0;
               unique case (cmd.kind)
                  KIND_WRITE: state_in = ST_WR;
                  KIND_READ:  state_in = ST_RD;
                  KIND_FIND: begin
                     mem_ra   = '0;
                     state_in = ST_ROOT;
                  end
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_WR: begin
            // write this level, read the parent's pair
            mem_we  = 1'b1;
            mem_wd  = pair_new;
            cur_in  = |pair_new;
            node_in = {1'b0, node_ff[NODE_W-1:1]};
            mem_ra  = IDX_W'(node_ff[NODE_W-1:2]);
            if (node_ff[NODE_W-1:1] == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            res_in.bit_read = rd_data_ff[node_ff[0]];
            state_in        = ST_DONE;
         end
         ST_ROOT: begin
            if (!rd_data_ff[1]) begin
               res_in.found_index = FOUND_W'(SIZE);
               res_in.none_found  = 1'b1;
               state_in           = ST_DONE;
            end else begin
               state_in = ST_CLIMB;
            end
         end
         ST_CLIMB: begin
            if (rd_data_ff[node_ff[0]]) begin
               if (node_ff[IDX_W]) begin
                  res_in.found_index = FOUND_W'(node_ff[IDX_W-1:0]);
                  state_in           = ST_DONE;
               end else begin
                  mem_ra   = node_ff[IDX_W-1:0];
                  state_in = ST_DESC;
               end
            end else begin
               node_in = climb_next;
               if (climb_next == NODE_W'(1)) begin
                  mem_ra   = IDX_W'(1);
                  state_in = ST_DESC;
               end else begin
                  mem_ra = climb_next[NODE_W-1:1];
               end
            end
         end
         ST_DESC: begin
            node_in = desc_next;
            mem_ra  = desc_next[IDX_W-1:0];
            if (desc_next[IDX_W]) begin
               res_in.found_index = FOUND_W'(desc_next[IDX_W-1:0]);
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_hold) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      node_ff <= node_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
   end

   assign status.ready = (state_ff == ST_IDLE);
   assign status.done  = done;
   assign result       = res_ff;

   // a set node always has a set child
   a_desc_child_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DESC) |-> (rd_data_ff != 2'b00))
      else $error("descent reached a pair with no set child");

   a_desc_internal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DESC) |-> !node_ff[IDX_W])
      else $error("descent node is a leaf");

   a_climb_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLIMB) |-> (node_ff != '0))
      else $error("climb node is zero");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> (!done && state_ff == ST_IDLE))
      else $error("done not followed by idle");

endmodule

### rtl/core/wrapping_next_set_bit_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_next_set_bit_finder_unit
// 1024-bit bitmap with write, read and wrapping find-next-set-bit.
//
//   channel | ports                          | word
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_stall, req_word | kind, bit_index, set_value
//   result  | rsp_valid, rsp_stall, rsp_word | bit_read, found_index, none_found
//
// One word at a time. Write: one memory write per tree level, up to the
// root. Read: one memory read. Find: one memory read per step of the tree
// climb and descent; the pair memory has a single read port.
// After reset a pass clears all 1024 entries; req_stall is high then.
// A new request is taken while the previous result waits on rsp_stall.
// ----------------------------------------------------------------------------
module wrapping_next_set_bit_finder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wnsb_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wnsb_pkg::rsp_type rsp_word
);
   import wnsb_pkg::*;

   wnsb_status_type status;
   rsp_type         result;
   logic            start;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_word_ff, rsp_word_in;

   assign req_stall = !status.ready;
   assign start     = req_valid && status.ready;

   wnsb_tree u_tree (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (req_word),
      .out_hold (rsp_valid_ff && rsp_stall),
      .status   (status),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
